/* rtl/core/bounded_fifo_lifo_queue_top_defines.svh */
// ----------------------------------------------------------------------------
// bounded_fifo_lifo_queue_top_defines.svh
// Assertion macros used by the checker file of the bounded queue.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_FIFO_LIFO_QUEUE_TOP_DEFINES_SVH
`define BOUNDED_FIFO_LIFO_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low
`define BFLQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked while rst_n is low
`define BFLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bflq_pkg.sv */
// ----------------------------------------------------------------------------
// bflq_pkg
// Types, sizes and codes shared by the bounded queue modules.
// ----------------------------------------------------------------------------
package bflq_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;

  // Command codes
  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_CLR = 2'd2;

  // Configuration register indexes
  localparam int         CFG_IDX_W = 2;
  localparam int         CFG_W     = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFO_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd1;

  typedef struct packed {
    logic [1:0]        command;
    logic [DATA_W-1:0] message_in;
  } in_item_t;

  typedef struct packed {
    logic              message_valid;
    logic [DATA_W-1:0] message_out;
    logic              dropped;
    logic              is_empty;
    logic [CNT_W-1:0]  fill_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic take;   // latch the input transfer
    logic exec;   // apply the latched command to the store
    logic load;   // move the pending result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

/* rtl/core/bounded_fifo_lifo_queue_top.sv */
// ----------------------------------------------------------------------------
// bounded_fifo_lifo_queue_top
// Bounded message ring with queue or stack policy and drop on overflow.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  command, message_in
//   out_     output     out_valid / out_stall message_valid, message_out,
//                                            dropped, is_empty, fill_count
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// A command holds the sequencer through its steps: latch, one ring access (a
// single-port read or write), hand-off. Its result is registered in the
// pending registers and read data, then loaded into the output register in
// the hand-off step; no new input transfer is taken before the hand-off.
// A stalled output register holds the sequencer in its hand-off step.
// Reset is synchronous on rst_n and empties the ring; no clearing pass.
// ----------------------------------------------------------------------------
module bounded_fifo_lifo_queue_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bflq_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bflq_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [bflq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bflq_pkg::CFG_W-1:0]     cfg_data
);
  import bflq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer
  bflq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Ring and result path
  bflq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* rtl/core/bflq_ctrl.sv */
// ----------------------------------------------------------------------------
// bflq_ctrl
// Sequencer of the bounded queue: accept, execute, hand off the result.
// ----------------------------------------------------------------------------
module bflq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bflq_pkg::dp_stat_t stat,
  output bflq_pkg::ctrl_cmd_t cmd
);
  import bflq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_PUSH;
      S_PUSH: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands to the datapath
  assign in_stall = (state_r != S_IDLE);
  assign cmd.take = (state_r == S_IDLE) && in_valid;
  assign cmd.exec = (state_r == S_EXEC);
  assign cmd.load = (state_r == S_PUSH) && stat.out_free;

endmodule

/* rtl/core/bflq_dpath.sv */
// ----------------------------------------------------------------------------
// bflq_dpath
// Ring store, front index, fill count, config registers and output register.
// ----------------------------------------------------------------------------
module bflq_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bflq_pkg::in_item_t                in_data,
  input  logic                              cfg_we,
  input  logic [bflq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bflq_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bflq_pkg::out_item_t               out_data,
  input  bflq_pkg::ctrl_cmd_t               cmd,
  output bflq_pkg::dp_stat_t                stat
);
  import bflq_pkg::*;

  // Configuration
  logic             lifo_r;
  logic [CNT_W-1:0] max_r;

  // Ring state
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Latched command
  in_item_t         item_r;

  // Pending result
  logic             pend_valid_r, pend_drop_r;
  logic [CNT_W-1:0] pend_fill_r;

  // Store
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic              we, re, vld, drop;
  logic [IDX_W-1:0]  waddr, raddr;

  // Output register
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Limit and drop decision
  logic [CNT_W-1:0] limit;
  logic             at_limit;
  logic [IDX_W-1:0] front_drop;
  logic [CNT_W-1:0] count_drop;

  assign limit = (max_r == '0 || max_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_r;
  assign at_limit = (count_r >= limit) && (count_r != '0);
  assign front_drop = (at_limit && !lifo_r) ? front_r + IDX_W'(1) : front_r;
  assign count_drop = at_limit ? count_r - CNT_W'(1) : count_r;

  // Command execution
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = front_r;
    raddr     = front_r;
    vld       = 1'b0;
    drop      = 1'b0;
    case (item_r.command)
      CMD_ENQ: begin
        we   = 1'b1;
        drop = at_limit;
        if (!lifo_r) begin
          // count_drop is below DEPTH here, its low bits are the offset
          waddr     = front_drop + count_drop[IDX_W-1:0];
          front_nxt = front_drop;
        end else begin
          waddr     = front_drop - IDX_W'(1);
          front_nxt = front_drop - IDX_W'(1);
        end
        count_nxt = count_drop + CNT_W'(1);
      end
      CMD_DEQ: begin
        if (count_r != '0) begin
          re        = 1'b1;
          vld       = 1'b1;
          front_nxt = front_r + IDX_W'(1);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_CLR: begin
        front_nxt = '0;
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifo_r  <= 1'b0;
      max_r   <= '0;
      front_r <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_LIFO_MODE) lifo_r <= cfg_data[0];
      if (cfg_we && cfg_index == CFG_MAX_ENTRIES) max_r <= cfg_data[CNT_W-1:0];
      if (cmd.exec) begin
        front_r <= front_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Input latch and pending result
  always_ff @(posedge clk) begin
    if (cmd.take) item_r <= in_data;
    if (cmd.exec) begin
      pend_valid_r <= vld;
      pend_drop_r  <= drop;
      pend_fill_r  <= count_nxt;
    end
  end

  // Ring memory, one write or one read per command
  always_ff @(posedge clk) begin
    if (cmd.exec && we) mem[waddr] <= item_r.message_in;
    if (cmd.exec && re) rdata_r <= mem[raddr];
  end

  // Output register
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.message_valid <= pend_valid_r;
      out_data_r.message_out   <= pend_valid_r ? rdata_r : '0;
      out_data_r.dropped       <= pend_drop_r;
      out_data_r.is_empty      <= (pend_fill_r == '0);
      out_data_r.fill_count    <= pend_fill_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/bflq_checker.sv */
// ----------------------------------------------------------------------------
// bflq_checker
// Port-level checks on the result channel of the bounded queue.
// ----------------------------------------------------------------------------
`include "bounded_fifo_lifo_queue_top_defines.svh"

module bflq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input bflq_pkg::out_item_t out_data
);
  import bflq_pkg::*;

  // A stalled result stays put until its transfer
  `BFLQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // Fill never exceeds the store
  `BFLQ_ASSERT_IMPL(a_fill_max, out_valid, out_data.fill_count <= CNT_W'(DEPTH), "fill above depth")

  // Empty flag agrees with the fill count
  `BFLQ_ASSERT_IMPL(a_empty, out_valid, out_data.is_empty == (out_data.fill_count == '0), "empty flag mismatch")

  // No message means a zero payload
  `BFLQ_ASSERT_IMPL(a_msg_zero, out_valid && !out_data.message_valid, out_data.message_out == '0, "payload without message")

  // A dequeue never drops and an enqueue never returns a message
  `BFLQ_ASSERT_IMPL(a_excl, out_valid, !(out_data.message_valid && out_data.dropped), "message and drop together")

endmodule

bind bounded_fifo_lifo_queue_top bflq_checker u_bflq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/tb_bounded_fifo_lifo_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_fifo_lifo_queue_top
// Self-checking bench for the bounded message ring. A directed table covers
// the empty store, the unused command code, clears, drops in both policies
// and the limit at one entry. Random phases then run through queue and stack
// policies and several limits (zero, one, the full ring, above the ring and a
// limit lowered under the current fill). A behavioral copy of the ring
// predicts every result; results are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_bounded_fifo_lifo_queue_top;
  import bflq_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         IDLE_PCT      = 22;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 6;
  localparam int         CYCLE_LIMIT   = 200000;

  // Directed table row: either a register write or one command transfer
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    in_item_t             cmd;
    bit                   typed;
    out_item_t            want;
  } dir_row_t;

  typedef struct {
    bit               lifo;
    logic [CFG_W-1:0] limit;
    int               n_items;
    int               enq_pct;
    bit               idle;
    bit               hold;
  } phase_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Behavioral ring and its configuration
  logic [DATA_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]  ring_front = '0;
  logic [CNT_W-1:0]  ring_count = '0;
  logic              mode_lifo  = 1'b0;
  logic [CFG_W-1:0]  limit_cfg  = '0;

  out_item_t predicted_replies [$];
  dir_row_t  dir_rows [$];
  phase_t    phases [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        idle_on = 1'b1;
  bit        hold_req = 1'b0;

  bounded_fifo_lifo_queue_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Predict the result of one command and advance the ring
  function automatic out_item_t apply_ring_command(input in_item_t it);
    out_item_t        r;
    logic [CNT_W-1:0] cap;
    r = '0;
    cap = (limit_cfg == '0 || limit_cfg > CFG_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(limit_cfg);
    case (it.command)
      CMD_ENQ: begin
        // at the limit: discard front (queue) or back (stack) first
        if (ring_count >= cap && ring_count != '0) begin
          if (!mode_lifo) ring_front = ring_front + IDX_W'(1);
          ring_count = ring_count - CNT_W'(1);
          r.dropped = 1'b1;
        end
        if (!mode_lifo) begin
          ring_words[IDX_W'(ring_front + ring_count[IDX_W-1:0])] = it.message_in;
        end else begin
          ring_front = ring_front - IDX_W'(1);
          ring_words[ring_front] = it.message_in;
        end
        ring_count = ring_count + CNT_W'(1);
      end
      CMD_DEQ: begin
        if (ring_count != '0) begin
          r.message_valid = 1'b1;
          r.message_out = ring_words[ring_front];
          ring_front = ring_front + IDX_W'(1);
          ring_count = ring_count - CNT_W'(1);
        end
      end
      CMD_CLR: begin
        ring_count = '0;
        ring_front = '0;
      end
      default: ;
    endcase
    r.is_empty = (ring_count == '0);
    r.fill_count = ring_count;
    return r;
  endfunction

  function automatic in_item_t make_cmd(input logic [1:0] c, input logic [DATA_W-1:0] m);
    in_item_t it;
    it.command = c;
    it.message_in = m;
    return it;
  endfunction

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_cmd(input logic [1:0] c, input logic [DATA_W-1:0] m);
    dir_row_t row;
    row = '{default: '0};
    row.cmd = make_cmd(c, m);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Command row whose result is known at a glance
  task automatic add_typed(input logic [1:0] c, input logic [DATA_W-1:0] m,
                           input logic v, input logic [DATA_W-1:0] msg,
                           input logic d, input logic e, input logic [CNT_W-1:0] f);
    dir_row_t row;
    row = '{default: '0};
    row.cmd = make_cmd(c, m);
    row.typed = 1'b1;
    row.want.message_valid = v;
    row.want.message_out = msg;
    row.want.dropped = d;
    row.want.is_empty = e;
    row.want.fill_count = f;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_phase(input bit lifo, input logic [CFG_W-1:0] lim, input int n,
                           input int enq, input bit idle, input bit hold);
    phase_t p;
    p.lifo = lifo;
    p.limit = lim;
    p.n_items = n;
    p.enq_pct = enq;
    p.idle = idle;
    p.hold = hold;
    phases.insert(phases.size(), p);
  endtask

  // Offer one command; record its expected result once the transfer happens
  task automatic send_command(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = apply_ring_command(it);
    predicted_replies.insert(predicted_replies.size(), typed ? want : pred);
  endtask

  // Stop sending and wait until every pending result has come out
  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LIFO_MODE) mode_lifo = val[0];
    else if (idx == CFG_MAX_ENTRIES) limit_cfg = val;
  endtask

  // Compare one result transfer against the oldest expectation
  task automatic check_reply(input out_item_t got);
    out_item_t want;
    if (predicted_replies.size() == 0) begin
      $error("result transfer with nothing pending: %p", got);
      mismatch_count++;
    end else begin
      want = predicted_replies[0];
      predicted_replies.delete(0);
      if (got.message_valid !== want.message_valid) begin
        $error("message_valid: expected %0d, got %0d", want.message_valid, got.message_valid);
        mismatch_count++;
      end
      if (got.message_out !== want.message_out) begin
        $error("message_out: expected %h, got %h", want.message_out, got.message_out);
        mismatch_count++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
        mismatch_count++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
        mismatch_count++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
        mismatch_count++;
      end
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_reply(out_data);
  end

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bounded_fifo_lifo_queue_top regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    out_item_t none;
    in_item_t  it;
    int        pick;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    // empty store, unused code, clear, queue order
    add_typed(CMD_DEQ, 32'h0000_0000, 0, 32'h0, 0, 1, 0);
    add_typed(CMD_UNUSED, 32'h0000_0000, 0, 32'h0, 0, 1, 0);
    add_typed(CMD_CLR, 32'hFFFF_FFFF, 0, 32'h0, 0, 1, 0);
    add_typed(CMD_ENQ, 32'hFFFF_FFFF, 0, 32'h0, 0, 0, 1);
    add_typed(CMD_ENQ, 32'h0000_0000, 0, 32'h0, 0, 0, 2);
    add_typed(CMD_ENQ, 32'hA5A5_A5A5, 0, 32'h0, 0, 0, 3);
    add_typed(CMD_UNUSED, 32'hDEAD_BEEF, 0, 32'h0, 0, 0, 3);
    add_typed(CMD_DEQ, 32'h0000_0000, 1, 32'hFFFF_FFFF, 0, 0, 2);
    add_typed(CMD_CLR, 32'h0000_0000, 0, 32'h0, 0, 1, 0);
    // queue drop at a limit of two: oldest goes
    add_cfg(CFG_MAX_ENTRIES, 7'd2);
    add_typed(CMD_ENQ, 32'h1111_1111, 0, 32'h0, 0, 0, 1);
    add_typed(CMD_ENQ, 32'h2222_2222, 0, 32'h0, 0, 0, 2);
    add_typed(CMD_ENQ, 32'h3333_3333, 0, 32'h0, 1, 0, 2);
    add_typed(CMD_DEQ, 32'h0000_0000, 1, 32'h2222_2222, 0, 0, 1);
    // stack mode: push at front, drop at back
    add_cfg(CFG_LIFO_MODE, 7'd1);
    add_typed(CMD_ENQ, 32'h4444_4444, 0, 32'h0, 0, 0, 2);
    add_typed(CMD_ENQ, 32'h5555_5555, 0, 32'h0, 1, 0, 2);
    add_typed(CMD_DEQ, 32'h0000_0000, 1, 32'h5555_5555, 0, 0, 1);
    add_typed(CMD_DEQ, 32'h0000_0000, 1, 32'h4444_4444, 0, 1, 0);
    add_typed(CMD_DEQ, 32'h0000_0000, 0, 32'h0, 0, 1, 0);
    // limit of one entry
    add_cfg(CFG_MAX_ENTRIES, 7'd1);
    add_typed(CMD_ENQ, 32'h8000_0000, 0, 32'h0, 0, 0, 1);
    add_typed(CMD_ENQ, 32'h0000_0001, 0, 32'h0, 1, 0, 1);
    add_typed(CMD_DEQ, 32'h0000_0000, 1, 32'h0000_0001, 0, 1, 0);
    // limit above the ring
    add_cfg(CFG_MAX_ENTRIES, 7'd127);
    add_cmd(CMD_ENQ, 32'h1234_5678);
    add_cmd(CMD_ENQ, 32'h9ABC_DEF0);
    add_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
    add_cmd(CMD_DEQ, 32'h0000_0000);

    // lifo, limit, items, enqueue percent, idling, hold-off
    add_phase(0, 7'd0,   200, 85, 1, 0);  // fills the whole ring, then drops
    add_phase(0, 7'd4,   120, 60, 1, 0);  // limit lowered under the fill
    add_phase(1, 7'd127, 200, 80, 1, 1);  // long receiver hold-off
    add_phase(1, 7'd64,  150, 55, 0, 0);  // no idling on either side
    add_phase(0, 7'd1,   100, 50, 1, 0);
    add_phase(1, 7'd1,   100, 50, 1, 0);
    add_phase(0, 7'd17,  150, 65, 1, 0);
    add_phase(1, 7'd0,   150, 70, 1, 0);
    add_phase(0, 7'd100, 130, 75, 1, 0);
    add_phase(1, 7'd5,   100, 50, 1, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_replies();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_command(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases; the store is not cleared between them
    foreach (phases[p]) begin
      drain_replies();
      write_reg(CFG_LIFO_MODE, CFG_W'(phases[p].lifo));
      write_reg(CFG_MAX_ENTRIES, phases[p].limit);
      idle_on = phases[p].idle;
      if (phases[p].hold) hold_req = 1'b1;
      repeat (phases[p].n_items) begin
        pick = $urandom_range(999);
        if (pick < phases[p].enq_pct * 10) it.command = CMD_ENQ;
        else if (pick < 990) it.command = CMD_DEQ;
        else if (pick < 995) it.command = CMD_CLR;
        else it.command = CMD_UNUSED;
        it.message_in = $urandom();
        send_command(it, 1'b0, none);
      end
    end

    drain_replies();
    if (mismatch_count == 0) begin
      $display("bounded_fifo_lifo_queue_top regression: pass");
    end else begin
      $display("bounded_fifo_lifo_queue_top regression: fail");
    end
    $finish;
  end

endmodule
